FILE: rtl/ulmf_pkg.sv
package ulmf_pkg;

    // ring of stored distances
    localparam int WINDOW = 5;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RANK_W = $clog2(WINDOW + 1);
    localparam int MID    = WINDOW / 2;

    // field widths
    localparam int ECHO_W   = 15;
    localparam int DIST_W   = 16;
    localparam int HEIGHT_W = 9;
    localparam int CAP_W    = 17;
    localparam int LEVEL_W  = 14;
    localparam int VOL_W    = 20;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // shared multiplier and divider widths
    localparam int MUL_W  = 17;
    localparam int DIVD_W = 32;
    localparam int DIVS_W = 16;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    // constants of the conversion
    localparam logic [DIST_W-1:0] DIST_MIN   = 16'd500;
    localparam logic [DIST_W-1:0] DIST_MAX   = 16'd45000;
    localparam logic [DIST_W-1:0] RING_RESET = 16'd10000;
    localparam logic [MUL_W-1:0]  DIST_MUL   = 17'd343;
    localparam logic [DIVS_W-1:0] DIST_DIV   = 16'd200;
    localparam logic [MUL_W-1:0]  LVL_MUL    = 17'd10000;
    localparam logic [DIVS_W-1:0] VOL_DIV    = 16'd1000;
    localparam logic [DIST_W-1:0] CM_SCALE   = 16'd100;
    localparam logic [VOL_W-1:0]  VOL_MAX    = 20'hFFFFF;

    // configuration reset values
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd200;
    localparam logic [HEIGHT_W-1:0] OFFSET_RESET = 9'd20;
    localparam logic [CAP_W-1:0]    CAP_RESET    = 17'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TANK_HEIGHT   = 2'd0,
        CFG_SENSOR_OFFSET = 2'd1,
        CFG_CAPACITY      = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_RING_WR,
        ST_MED_GO,
        ST_MED_WAIT,
        ST_HEIGHT,
        ST_LVL_GO,
        ST_LVL_WAIT,
        ST_VOL_GO,
        ST_VOL_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic wr_en;
        logic start;
    } med_ctl_t;

endpackage

FILE: rtl/ulmf_div.sv
module ulmf_div
    import ulmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVD_W-1:0] quot_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, quot_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIVD_W-2:0], fits};
            if (fits) begin
                rem_reg <= DIVS_W'(trial - {1'b0, divisor_reg});
            end else begin
                rem_reg <= trial[DIVS_W-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/ulmf_med.sv
module ulmf_med
    import ulmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  med_ctl_t          ctl,
    input  logic [DIST_W-1:0] wr_data,
    output logic              done,
    output logic [DIST_W-1:0] median
);

    logic [DIST_W-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] cand_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIST_W-1:0] med_reg;
    logic [DIST_W-1:0] cand_val;
    logic [RANK_W-1:0] rank;

    // rank of the candidate, ties broken by slot order
    assign cand_val = ring_reg[cand_reg];
    always_comb begin
        rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if ((ring_reg[j] < cand_val) ||
                ((ring_reg[j] == cand_val) && (SLOT_W'(j) < cand_reg))) begin
                rank = rank + 1'b1;
            end
        end
    end

    // ring write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= RING_RESET;
            end
            slot_reg <= '0;
        end else if (ctl.wr_en) begin
            ring_reg[slot_reg] <= wr_data;
            if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                slot_reg <= '0;
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // candidate scan, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cand_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cand_reg <= '0;
            end else if (busy_reg) begin
                if (cand_reg == SLOT_W'(WINDOW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cand_reg <= cand_reg + 1'b1;
                end
            end
        end
    end

    // capture the middle element
    always_ff @(posedge aclk) begin
        if (busy_reg && (rank == RANK_W'(MID))) begin
            med_reg <= cand_val;
        end
    end

    assign done   = done_reg;
    assign median = med_reg;

endmodule

FILE: rtl/ultrasonic_level_median_filter.sv
// Ultrasonic tank level filter with a five-entry median ring.
// Input stream s_*: one word per echo, s_tdata[14:0] is the echo width in us.
// Output stream m_*: one word per accepted echo; m_tuser is the healthy flag,
// m_tdata carries median distance (0.01 cm), level (0.01 %) and volume (dl).
// Tank height, sensor offset and capacity are set through the cfg_* write
// port, indexes 0, 1 and 2; write them only while the block is idle.
// Each echo is worked through a sequencer around one multiplier and one
// radix-2 restoring divider: distance, level and volume each need one pass
// (level and volume only when the offset is below the height), and the
// median scan checks one ring entry per cycle. s_tready is high only while
// idle, so a new echo is not taken before the last one is worked through.
// The finished word sits in an output register, so the next echo is taken
// while the receiver stalls; a second word waits in the last step until the
// register is free.
// Synchronous active-low reset: ring filled with 100 cm, write slot 0,
// registers back to 200 cm, 20 cm and 1000 l, no word pending.
module ultrasonic_level_median_filter
    import ulmf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,     // [14:0] echo_width_us
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,     // [15:0] median_distance,
                                              // [29:16] level_hundredths_pct,
                                              // [49:30] volume_deciliters
    output logic [0:0]           m_tuser,     // [0] healthy
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] offset_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [ECHO_W-1:0]   echo_reg;
    logic                healthy_reg;
    logic [DIST_W-1:0]   h_reg;
    logic [DIST_W-1:0]   eff_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic                m_valid_reg;
    logic                out_healthy_reg;
    logic [DIST_W-1:0]   out_median_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [VOL_W-1:0]    out_vol_reg;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    div_req_t            div_req;
    logic                div_done;
    logic [DIVD_W-1:0]   quotient;
    med_ctl_t            med_ctl;
    logic                med_done;
    logic [DIST_W-1:0]   median;
    logic [DIST_W-1:0]   distance;
    logic                in_window;
    logic                geom_ok;
    logic [DIST_W-1:0]   full_cm;
    logic [DIST_W-1:0]   eff_cm;
    logic [DIST_W-1:0]   h_raw;
    logic                out_free;
    logic                s_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // shared units
    assign mul_p = mul_a * mul_b;

    ulmf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    ulmf_med u_med (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (med_ctl),
        .wr_data (distance),
        .done    (med_done),
        .median  (median)
    );

    // distance window check
    assign distance  = quotient[DIST_W-1:0];
    assign in_window = (distance > DIST_MIN) && (distance < DIST_MAX);

    // tank geometry in 0.01 cm
    assign geom_ok = (offset_reg < height_reg);
    assign full_cm = DIST_W'({7'b0, height_reg} * CM_SCALE);
    assign eff_cm  = DIST_W'(({7'b0, height_reg} - {7'b0, offset_reg}) * CM_SCALE);
    assign h_raw   = (full_cm > median) ? (full_cm - median) : '0;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_RESET;
            offset_reg <= OFFSET_RESET;
            cap_reg    <= CAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TANK_HEIGHT:   height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_SENSOR_OFFSET: offset_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_CAPACITY:      cap_reg    <= cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_fire) state_next = ST_DIST_GO;
            ST_DIST_GO:   state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: if (div_done) state_next = ST_RING_WR;
            ST_RING_WR:   state_next = ST_MED_GO;
            ST_MED_GO:    state_next = ST_MED_WAIT;
            ST_MED_WAIT:  if (med_done) state_next = ST_HEIGHT;
            ST_HEIGHT:    state_next = geom_ok ? ST_LVL_GO : ST_FINISH;
            ST_LVL_GO:    state_next = ST_LVL_WAIT;
            ST_LVL_WAIT:  if (div_done) state_next = ST_VOL_GO;
            ST_VOL_GO:    state_next = ST_VOL_WAIT;
            ST_VOL_WAIT:  if (div_done) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: operand selection and unit starts
    always_comb begin
        s_tready         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.divisor  = '0;
        med_ctl.wr_en    = 1'b0;
        med_ctl.start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DIST_GO: begin
                mul_a           = {2'b0, echo_reg};
                mul_b           = DIST_MUL;
                div_req.start   = 1'b1;
                div_req.divisor = DIST_DIV;
            end
            ST_RING_WR: med_ctl.wr_en = in_window;
            ST_MED_GO:  med_ctl.start = 1'b1;
            ST_LVL_GO: begin
                mul_a           = {1'b0, h_reg};
                mul_b           = LVL_MUL;
                div_req.start   = 1'b1;
                div_req.divisor = eff_reg;
            end
            ST_VOL_GO: begin
                mul_a           = {3'b0, level_reg};
                mul_b           = cap_reg;
                div_req.start   = 1'b1;
                div_req.divisor = VOL_DIV;
            end
            default: ;
        endcase
        div_req.dividend = mul_p[DIVD_W-1:0];
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            echo_reg <= s_tdata[ECHO_W-1:0];
        end
        if (state_reg == ST_RING_WR) begin
            healthy_reg <= in_window;
        end
        if (state_reg == ST_HEIGHT) begin
            h_reg     <= (h_raw > eff_cm) ? eff_cm : h_raw;
            eff_reg   <= eff_cm;
            level_reg <= '0;
            vol_reg   <= '0;
        end
        if ((state_reg == ST_LVL_WAIT) && div_done) begin
            level_reg <= quotient[LEVEL_W-1:0];
        end
        if ((state_reg == ST_VOL_WAIT) && div_done) begin
            vol_reg <= (|quotient[DIVD_W-1:VOL_W]) ? VOL_MAX : quotient[VOL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FINISH) && out_free) begin
            out_healthy_reg <= healthy_reg;
            out_median_reg  <= median;
            out_level_reg   <= level_reg;
            out_vol_reg     <= vol_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_healthy_reg;
    assign m_tdata  = {6'b0, out_vol_reg, out_level_reg, out_median_reg};

endmodule

FILE: tb/ulmf_report_checker.sv
module ulmf_report_checker
    import ulmf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,     // [14:0] echo_width_us
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [55:0]          m_tdata,     // [15:0] median_distance,
                                              // [29:16] level_hundredths_pct,
                                              // [49:30] volume_deciliters
    input  logic [0:0]           m_tuser,     // [0] healthy
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_words
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                healthy;
        logic [DIST_W-1:0]   median;
        logic [LEVEL_W-1:0]  level;
        logic [VOL_W-1:0]    volume;
    } level_report_t;

    // own copy of the tank settings and the distance ring
    logic [HEIGHT_W-1:0] height_cm = HEIGHT_RESET;
    logic [HEIGHT_W-1:0] offset_cm = OFFSET_RESET;
    logic [CAP_W-1:0]    capacity  = CAP_RESET;
    logic [DIST_W-1:0]   dist_ring [WINDOW];
    int                  ring_slot = 0;

    level_report_t expected_reports [$];
    int            mismatches = 0;

    assign fail_count    = mismatches;
    assign pending_words = expected_reports.size();

    // convert one echo, update the ring and work out the report it causes
    function automatic level_report_t predict_reading(input logic [ECHO_W-1:0] echo);
        logic [31:0]       distance;
        logic [DIST_W-1:0] sorted [WINDOW];
        logic [DIST_W-1:0] held;
        logic [31:0]       full, eff, water, level;
        logic [63:0]       decilitres;
        level_report_t     rep;
        int                i, j;
        distance = (32'(echo) * 32'(DIST_MUL)) / 32'(DIST_DIV);
        rep.healthy = 1'b0;
        // only readings strictly inside the window enter the ring
        if (distance > 32'(DIST_MIN) && distance < 32'(DIST_MAX)) begin
            dist_ring[ring_slot] = DIST_W'(distance);
            ring_slot = (ring_slot + 1) % WINDOW;
            rep.healthy = 1'b1;
        end
        // insertion sort of a copy, middle entry is the median
        for (i = 0; i < WINDOW; i++) sorted[i] = dist_ring[i];
        for (i = 1; i < WINDOW; i++) begin
            held = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > held) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = held;
        end
        rep.median = sorted[MID];
        level = '0;
        decilitres = '0;
        // level and volume stay zero unless the offset is below the height
        if (offset_cm < height_cm) begin
            eff   = 32'(height_cm - offset_cm) * 32'(CM_SCALE);
            full  = 32'(height_cm) * 32'(CM_SCALE);
            water = (full > 32'(rep.median)) ? full - 32'(rep.median) : 32'd0;
            if (water > eff) water = eff;
            level = (water * 32'(LVL_MUL)) / eff;
            decilitres = (64'(level) * 64'(capacity)) / 64'(VOL_DIV);
            if (decilitres > 64'(VOL_MAX)) decilitres = 64'(VOL_MAX);
        end
        rep.level  = LEVEL_W'(level);
        rep.volume = VOL_W'(decilitres);
        return rep;
    endfunction

    // watch the register port and both streams
    always @(posedge aclk) begin
        level_report_t got, want;
        if (!aresetn) begin
            height_cm = HEIGHT_RESET;
            offset_cm = OFFSET_RESET;
            capacity  = CAP_RESET;
            for (int i = 0; i < WINDOW; i++) dist_ring[i] = RING_RESET;
            ring_slot = 0;
            expected_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TANK_HEIGHT:   height_cm = cfg_data[HEIGHT_W-1:0];
                    CFG_SENSOR_OFFSET: offset_cm = cfg_data[HEIGHT_W-1:0];
                    CFG_CAPACITY:      capacity  = cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
            // compare an outgoing word with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.healthy = m_tuser[0];
                got.median  = m_tdata[15:0];
                got.level   = m_tdata[29:16];
                got.volume  = m_tdata[49:30];
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word healthy %0d median %0d level %0d volume %0d",
                                 $time, got.healthy, got.median, got.level, got.volume);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch healthy %0d/%0d median %0d/%0d ",
                                      "level %0d/%0d volume %0d/%0d (expected/actual)"},
                                     $time, want.healthy, got.healthy, want.median, got.median,
                                     want.level, got.level, want.volume, got.volume);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_reports.push_back(predict_reading(s_tdata[ECHO_W-1:0]));
        end
    end

endmodule

FILE: tb/ultrasonic_level_median_filter_tb.sv
module ultrasonic_level_median_filter_tb;

    import ulmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;
    // echo widths at the edges of the valid distance window
    localparam int ECHO_LOW_OK  = 293;
    localparam int ECHO_HIGH_OK = 26239;
    localparam int ECHO_TOP     = 32767;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_SLOT = 2'd3;

    typedef enum logic [1:0] {
        RX_READY,
        RX_CHOPPY,
        RX_BLOCKED
    } rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;    // [14:0] echo_width_us
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;           // [15:0] median_distance,
                                             // [29:16] level_hundredths_pct,
                                             // [49:30] volume_deciliters
    logic [0:0]           m_tuser;           // [0] healthy
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int fail_count;
    int pending_words;

    // settings last written, used to aim echoes at the clamping points
    int tank_h   = HEIGHT_RESET;
    int tank_off = OFFSET_RESET;
    int burst_left = 0;

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ultrasonic_level_median_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ulmf_report_checker u_report_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // receiver back-pressure, switching between modes now and then
    rx_mode_t rx_mode   = RX_READY;
    int       mode_left = 300;
    int       stall_left = 0;

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(200, 1500);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_READY:  m_tready <= 1'b1;
            RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left == 0) begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 64);
                end else begin
                    m_tready <= 1'b0;
                    stall_left--;
                end
            end
        endcase
    end

    // watchdog on cycles without any word moving
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one echo word, with a random gap whenever a burst runs out
    task automatic send_word(input logic [ECHO_W-1:0] echo);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 30);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, echo};
        burst_left--;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every report has come back
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
    endtask

    // write all three tank settings plus the unused index
    task automatic configure(input int h, input int o, input int c);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TANK_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(negedge aclk);
        cfg_index <= CFG_SENSOR_OFFSET;
        cfg_data  <= CFG_W'(o);
        @(negedge aclk);
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= CFG_W'(c);
        @(negedge aclk);
        cfg_index <= CFG_UNUSED_SLOT;
        cfg_data  <= CFG_W'($urandom);
        @(negedge aclk);
        cfg_we <= 1'b0;
        tank_h   = h & ((1 << HEIGHT_W) - 1);
        tank_off = o & ((1 << HEIGHT_W) - 1);
    endtask

    // mostly readings in the window, many near the height and offset clamps
    function automatic logic [ECHO_W-1:0] pick_echo();
        int roll, target;
        int unsigned us;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            us = $urandom_range(ECHO_LOW_OK, ECHO_HIGH_OK);
        end else if (roll < 70) begin
            target = ($urandom_range(0, 1) ? tank_h : tank_off) * int'(CM_SCALE)
                     + int'($urandom_range(0, 1200)) - 600;
            if (target < 0) target = 0;
            us = (target * int'(DIST_DIV)) / int'(DIST_MUL);
        end else if (roll < 85) begin
            us = $urandom_range(0, 1) ? $urandom_range(ECHO_LOW_OK - 8, ECHO_LOW_OK + 7)
                                      : $urandom_range(ECHO_HIGH_OK - 7, ECHO_HIGH_OK + 7);
        end else if (roll < 90) begin
            us = 0;
        end else begin
            us = $urandom_range(0, 1) ? $urandom_range(1, ECHO_LOW_OK - 1)
                                      : $urandom_range(ECHO_HIGH_OK + 1, ECHO_TOP);
        end
        return ECHO_W'(us);
    endfunction

    task automatic run_phase(input int h, input int o, input int c, input int count);
        wait_idle();
        configure(h, o, c);
        repeat (count) send_word(pick_echo());
    endtask

    // timeout, window edges, full-scale bits, then clamping at both ends
    localparam int DIRECTED_ECHOES [22] = '{
        0, 1, ECHO_LOW_OK - 1, ECHO_LOW_OK, ECHO_HIGH_OK, ECHO_HIGH_OK + 1, 30000, ECHO_TOP,
        16384, 21845, 10922, 583, 583, 583, 12000, 12000, 12000, 12000,
        5000, 6000, 7000, ECHO_LOW_OK
    };

    initial begin
        int h;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ECHOES[i]) send_word(ECHO_W'(DIRECTED_ECHOES[i]));

        // extremes of the settings, offset at and above the height, saturation
        run_phase(450, 449, 100000, 90);
        run_phase(1, 0, 1, 90);
        run_phase(300, 300, 5000, 80);
        run_phase(100, 250, 2000, 80);
        run_phase(511, 511, 131071, 60);
        run_phase(511, 0, 131071, 90);
        run_phase(450, 0, 100000, 90);
        repeat (4) begin
            h = $urandom_range(1, 450);
            run_phase(h, $urandom_range(0, h - 1), $urandom_range(1, 100000), 90);
        end
        run_phase(HEIGHT_RESET, OFFSET_RESET, CAP_RESET, 80);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ulmf_pkg.sv
rtl/ulmf_div.sv
rtl/ulmf_med.sv
rtl/ultrasonic_level_median_filter.sv
tb/ulmf_report_checker.sv
tb/ultrasonic_level_median_filter_tb.sv
